/* design/csvfs_pkg.sv */
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants for the CSV field splitter: widths, character
// codes, the accepted input beat and the field descriptor.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    localparam int MaxLineLen = 2048;
    localparam int MaxFields  = 64;

    localparam int ByteW  = 8;
    localparam int PosW   = $clog2(MaxLineLen + 1);
    localparam int CntW   = $clog2(MaxFields + 1);
    localparam int LimitW = 7;
    localparam int IdxW   = 6;
    localparam int StartW = 11;
    localparam int LenW   = 12;
    localparam int DataW  = 32;

    localparam logic [LimitW-1:0] LimitReset = LimitW'(50);

    localparam logic [ByteW-1:0] QUOTE_CH = 8'h22;
    localparam logic [ByteW-1:0] COMMA_CH = 8'h2C;
    localparam logic [ByteW-1:0] LF_CH    = 8'h0A;
    localparam logic [ByteW-1:0] CR_CH    = 8'h0D;

    typedef struct packed {
        logic [ByteW-1:0] line_byte;
        logic             end_of_line;
    } in_beat_t;

    typedef struct packed {
        logic              line_overflow;
        logic              last_field;
        logic [LenW-1:0]   field_length;
        logic [StartW-1:0] field_start;
        logic [IdxW-1:0]   field_index;
    } desc_t;

endpackage

/* design/csv_field_splitter_core.sv */
// ----------------------------------------------------------------------------
// csv_field_splitter_core
// Splits a stream of CSV line bytes into field descriptors (index, start,
// length, last flag, overflow flag).
//
//   channel | dir | handshake           | payload
//   s_      | in  | s_tvalid / s_tready | s_tdata byte, s_tlast end of line
//   m_      | out | m_tvalid / m_tready | m_tdata descriptor, m_tlast, m_tuser
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_data field limit
//
// One byte beat per clock while the result register can load; a beat waits in
// the input register, and its descriptor is loaded into the result register as
// the parser takes the beat.
// aresetn clears the line state, both stage valids, and sets the limit to 50.
// A stalled result beat holds; the input register still takes one more beat.
// ----------------------------------------------------------------------------
module csv_field_splitter_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] line_byte
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [csvfs_pkg::DataW-1:0]  m_tdata,   // [5:0] field_index,
                                                    // [16:6] field_start,
                                                    // [28:17] field_length
    output logic                         m_tlast,
    output logic                         m_tuser,   // [0] line_overflow
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [csvfs_pkg::LimitW-1:0] cfg_data
);
    import csvfs_pkg::*;

    logic [LimitW-1:0] field_limit_reg;
    in_beat_t          s_beat;
    in_beat_t          beat;
    logic              beat_valid;
    logic              can_load;
    logic              step;
    logic              res_valid;
    desc_t             res;
    desc_t             m_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_limit_reg <= LimitReset;
        end else if (cfg_valid && cfg_ready) begin
            field_limit_reg <= cfg_data;
        end
    end

    assign s_beat.line_byte   = s_tdata;
    assign s_beat.end_of_line = s_tlast;
    assign step               = beat_valid && can_load;

    csvfs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .pull       (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    csvfs_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .beat        (beat),
        .field_limit (field_limit_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    csvfs_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .desc     (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_desc   (m_desc)
    );

    assign m_tdata = {(DataW - IdxW - StartW - LenW)'(0),
                      m_desc.field_length, m_desc.field_start, m_desc.field_index};
    assign m_tlast = m_desc.last_field;
    assign m_tuser = m_desc.line_overflow;

endmodule

/* design/csvfs_in_stage.sv */
// ----------------------------------------------------------------------------
// csvfs_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module csvfs_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  csvfs_pkg::in_beat_t s_beat,
    input  logic                pull,
    output logic                beat_valid,
    output csvfs_pkg::in_beat_t beat
);
    import csvfs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign s_tready   = !valid_reg || pull;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (pull) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

/* design/csvfs_parser.sv */
// ----------------------------------------------------------------------------
// csvfs_parser
// Line state and field decode: tracks quotes, offsets and the last two bytes,
// and forms a descriptor when a comma or the end of the line closes a field.
// ----------------------------------------------------------------------------
module csvfs_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  csvfs_pkg::in_beat_t           beat,
    input  logic [csvfs_pkg::LimitW-1:0]  field_limit,
    output logic                          res_valid,
    output csvfs_pkg::desc_t              res
);
    import csvfs_pkg::*;

    logic             quoted_reg,   quoted_next;
    logic [PosW-1:0]  pos_reg,      pos_next;
    logic [PosW-1:0]  fstart_reg,   fstart_next;
    logic [CntW-1:0]  emitted_reg,  emitted_next;
    logic             swq_reg,      swq_next;
    logic [ByteW-1:0] prev_reg,     prev_next;
    logic [ByteW-1:0] prev2_reg,    prev2_next;
    logic             overflow_reg, overflow_next;

    logic [ByteW-1:0] c;
    logic [LimitW-1:0] lim;
    logic             active;
    logic             kept;
    logic             swq;
    logic             is_quote;
    logic             comma_hit;
    logic             eol_hit;
    logic             is_nl;
    logic             cr_pair;
    logic [PosW-1:0]  len_kept0;
    logic [PosW-1:0]  len_kept1;
    logic [PosW-1:0]  len_kept2;
    logic [ByteW-1:0] tail_kept1;
    logic [ByteW-1:0] tail_kept2;
    logic [PosW-1:0]  len_sel;
    logic [ByteW-1:0] tail_sel;
    logic             strip;
    logic [PosW-1:0]  start_adj;
    logic [PosW-1:0]  len_adj;

    always_comb begin
        c        = beat.line_byte;
        lim      = (field_limit > LimitW'(MaxFields)) ? LimitW'(MaxFields) : field_limit;
        active   = CntW'(emitted_reg) < CntW'(lim);
        kept     = pos_reg < PosW'(MaxLineLen);
        is_quote = (c == QUOTE_CH);
        swq      = (kept && pos_reg == fstart_reg) ? is_quote : swq_reg;

        comma_hit = active && kept && (c == COMMA_CH) && !quoted_reg;
        eol_hit   = active && beat.end_of_line && !comma_hit;

        // trim one LF or CR, then a CR before it
        len_kept0  = pos_reg + PosW'(1) - fstart_reg;
        is_nl      = (c == LF_CH) || (c == CR_CH);
        len_kept1  = is_nl ? len_kept0 - PosW'(1) : len_kept0;
        tail_kept1 = is_nl ? prev_reg : c;
        cr_pair    = is_nl && (len_kept1 != '0) && (prev_reg == CR_CH);
        len_kept2  = cr_pair ? len_kept1 - PosW'(1) : len_kept1;
        tail_kept2 = cr_pair ? prev2_reg : tail_kept1;

        if (comma_hit) begin
            len_sel  = pos_reg - fstart_reg;
            tail_sel = prev_reg;
        end else if (kept) begin
            len_sel  = len_kept2;
            tail_sel = tail_kept2;
        end else begin
            len_sel  = (pos_reg > fstart_reg) ? pos_reg - fstart_reg : '0;
            tail_sel = prev_reg;
        end

        strip     = (len_sel >= PosW'(2)) && swq && (tail_sel == QUOTE_CH);
        start_adj = strip ? fstart_reg + PosW'(1) : fstart_reg;
        len_adj   = strip ? len_sel - PosW'(2) : len_sel;

        res_valid         = comma_hit || eol_hit;
        res.field_index   = emitted_reg[IdxW-1:0];
        res.field_start   = (start_adj > PosW'((1 << StartW) - 1)) ?
                            StartW'((1 << StartW) - 1) : start_adj[StartW-1:0];
        res.field_length  = LenW'(len_adj);
        res.last_field    = comma_hit ?
                            (beat.end_of_line ||
                             (emitted_reg + CntW'(1) >= CntW'(lim))) : 1'b1;
        res.line_overflow = overflow_reg || !kept;
    end

    always_comb begin
        quoted_next   = quoted_reg;
        pos_next      = pos_reg;
        fstart_next   = fstart_reg;
        emitted_next  = emitted_reg;
        swq_next      = swq_reg;
        prev_next     = prev_reg;
        prev2_next    = prev2_reg;
        overflow_next = overflow_reg;
        if (beat.end_of_line) begin
            quoted_next   = 1'b0;
            pos_next      = '0;
            fstart_next   = '0;
            emitted_next  = '0;
            swq_next      = 1'b0;
            prev_next     = '0;
            prev2_next    = '0;
            overflow_next = 1'b0;
        end else if (active) begin
            if (!kept) begin
                overflow_next = 1'b1;
            end else begin
                swq_next    = swq;
                quoted_next = quoted_reg ^ is_quote;
                if (comma_hit) begin
                    emitted_next = emitted_reg + CntW'(1);
                    fstart_next  = pos_reg + PosW'(1);
                    swq_next     = 1'b0;
                end
                prev2_next = prev_reg;
                prev_next  = c;
                pos_next   = pos_reg + PosW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quoted_reg   <= 1'b0;
            pos_reg      <= '0;
            fstart_reg   <= '0;
            emitted_reg  <= '0;
            swq_reg      <= 1'b0;
            prev_reg     <= '0;
            prev2_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (step) begin
            quoted_reg   <= quoted_next;
            pos_reg      <= pos_next;
            fstart_reg   <= fstart_next;
            emitted_reg  <= emitted_next;
            swq_reg      <= swq_next;
            prev_reg     <= prev_next;
            prev2_reg    <= prev2_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

/* design/csvfs_out_stage.sv */
// ----------------------------------------------------------------------------
// csvfs_out_stage
// Result register: holds one field descriptor until the sink takes the beat.
// ----------------------------------------------------------------------------
module csvfs_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  csvfs_pkg::desc_t desc,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output csvfs_pkg::desc_t m_desc
);
    import csvfs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    desc_t desc_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_desc   = desc_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= desc;
        end
    end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csv_field_splitter_core. It opens with a short
// table of hand-built lines, mostly with their descriptors written out in
// full. Three over-long lines follow, then random lines under several field
// limits: well-formed CSV with random content, mixed with byte noise.
// Every accepted byte goes through an in-bench model of the splitter, and
// each descriptor beat is compared field by field with the oldest expected
// one. Both sides idle at random, and the receiver stalls for long stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import csvfs_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DataW-1:0]  m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LimitW-1:0] cfg_data;

    typedef struct {
        logic [7:0] c;
        logic       eol;
        bit         pinned;
        desc_t      d;
    } row_t;

    row_t       dir_rows[$];
    desc_t      desc_q[$];
    logic [7:0] line_q[$];
    int         errors;
    int         src_idle;
    int         dst_idle;
    int         hold_req;
    bit         pin_on;
    desc_t      pin_desc;

    // splitter state as the bench sees it
    logic [LimitW-1:0] lim_reg;
    bit                quote_mode;
    bit                open_quote;
    bit                over_flag;
    int unsigned       pos;
    int unsigned       fld_start;
    int unsigned       fld_count;
    logic [7:0]        prev_c;
    logic [7:0]        prev2_c;

    csv_field_splitter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(4_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void clear_line();
        quote_mode = 1'b0;
        open_quote = 1'b0;
        over_flag  = 1'b0;
        pos        = 0;
        fld_start  = 0;
        fld_count  = 0;
        prev_c     = 8'h00;
        prev2_c    = 8'h00;
    endfunction

    function automatic desc_t make_desc(int unsigned start, int unsigned len, bit last);
        desc_t d;
        d.field_index   = fld_count[IdxW-1:0];
        d.field_start   = (start > 2047) ? StartW'(2047) : start[StartW-1:0];
        d.field_length  = (len > 4095) ? LenW'(4095) : len[LenW-1:0];
        d.last_field    = last;
        d.line_overflow = over_flag;
        return d;
    endfunction

    // advance the line state by one byte; returns 1 when a field closes
    function automatic bit split_step(input logic [7:0] c, input logic eol,
                                      output desc_t d);
        int unsigned lim;
        int unsigned start;
        int unsigned len;
        logic [7:0]  tail;
        bit          kept;
        bit          closed;
        bit          got;
        lim    = (lim_reg > MaxFields) ? MaxFields : lim_reg;
        got    = 1'b0;
        closed = 1'b0;
        d      = '0;
        if (fld_count < lim) begin
            kept = (pos < MaxLineLen);
            if (!kept) begin
                over_flag = 1'b1;
            end else begin
                if (pos == fld_start)
                    open_quote = (c == QUOTE_CH);
                if (c == QUOTE_CH) begin
                    quote_mode = !quote_mode;
                end else if (c == COMMA_CH && !quote_mode) begin
                    start = fld_start;
                    len   = pos - start;
                    if (len >= 2 && open_quote && prev_c == QUOTE_CH) begin
                        start++;
                        len -= 2;
                    end
                    d = make_desc(start, len, eol || (fld_count + 1 >= lim));
                    got = 1'b1;
                    fld_count++;
                    fld_start  = pos + 1;
                    open_quote = 1'b0;
                    closed     = 1'b1;
                end
            end
            if (eol && !closed && fld_count < lim) begin
                start = fld_start;
                if (kept) begin
                    len  = pos + 1 - start;
                    tail = c;
                    if (c == LF_CH || c == CR_CH) begin
                        len--;
                        tail = prev_c;
                        if (len > 0 && prev_c == CR_CH) begin
                            len--;
                            tail = prev2_c;
                        end
                    end
                end else begin
                    len  = (pos > start) ? pos - start : 0;
                    tail = prev_c;
                end
                if (len >= 2 && open_quote && tail == QUOTE_CH) begin
                    start++;
                    len -= 2;
                end
                d = make_desc(start, len, 1'b1);
                got = 1'b1;
                fld_count++;
            end
            if (kept) begin
                prev2_c = prev_c;
                prev_c  = c;
                pos++;
            end
        end
        if (eol)
            clear_line();
        return got;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v,
                                        logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        desc_t want;
        desc_t seen;
        bit    hit;
        if (!aresetn) begin
            lim_reg = LimitReset;
            clear_line();
        end else begin
            if (cfg_valid && cfg_ready)
                lim_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                hit = split_step(s_tdata, s_tlast, want);
                if (pin_on)
                    desc_q.push_back(pin_desc);
                else if (hit)
                    desc_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                seen.field_index   = m_tdata[5:0];
                seen.field_start   = m_tdata[16:6];
                seen.field_length  = m_tdata[28:17];
                seen.last_field    = m_tlast;
                seen.line_overflow = m_tuser;
                if (desc_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected descriptor idx %0d start %0d len %0d",
                             $time, seen.field_index, seen.field_start,
                             seen.field_length);
                end else begin
                    want = desc_q.pop_front();
                    check_field("field_index", want.field_index, seen.field_index);
                    check_field("field_start", want.field_start, seen.field_start);
                    check_field("field_length", want.field_length, seen.field_length);
                    check_field("last_field", want.last_field, seen.last_field);
                    check_field("line_overflow", want.line_overflow, seen.line_overflow);
                end
            end
        end
    end

    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle);
            end
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == QUOTE_CH || c == COMMA_CH)
            c = 8'h61;
        return c;
    endfunction

    task automatic add_row(input logic [7:0] c, input logic eol, input bit pinned,
                           input int idx, input int start, input int len,
                           input bit last);
        row_t r;
        r.c                = c;
        r.eol              = eol;
        r.pinned           = pinned;
        r.d.field_index    = IdxW'(idx);
        r.d.field_start    = StartW'(start);
        r.d.field_length   = LenW'(len);
        r.d.last_field     = last;
        r.d.line_overflow  = 1'b0;
        dir_rows.push_back(r);
    endtask

    // call at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(input logic [7:0] c, input logic eol, input bit pinned,
                             input desc_t d);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        pin_on   = pinned;
        pin_desc = d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_beat(line_q[i], i == line_q.size() - 1, 1'b0, '0);
        if ($urandom_range(14) == 0) begin
            s_tvalid <= 1'b0;
            wait (desc_q.size() == 0);
            @(negedge aclk);
        end
    endtask

    task automatic set_limit(input logic [LimitW-1:0] v);
        s_tvalid <= 1'b0;
        wait (desc_q.size() == 0);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic gen_line();
        int nf;
        int n;
        line_q.delete();
        if ($urandom_range(5) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                case ($urandom_range(3))
                    0:       line_q.push_back(QUOTE_CH);
                    1:       line_q.push_back(COMMA_CH);
                    default: line_q.push_back(8'($urandom_range(1, 255)));
                endcase
            end
            return;
        end
        nf = ($urandom_range(11) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
        for (int i = 0; i < nf; i++) begin
            if (i > 0)
                line_q.push_back(COMMA_CH);
            case ($urandom_range(6))
                0: ;
                4: begin
                    line_q.push_back(QUOTE_CH);
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        case ($urandom_range(4))
                            0: line_q.push_back(COMMA_CH);
                            1: begin
                                line_q.push_back(QUOTE_CH);
                                line_q.push_back(QUOTE_CH);
                            end
                            default: line_q.push_back(plain_byte());
                        endcase
                    end
                    line_q.push_back(QUOTE_CH);
                end
                5: begin
                    repeat ($urandom_range(1, 4)) line_q.push_back(plain_byte());
                    line_q.push_back(QUOTE_CH);
                    line_q.push_back(plain_byte());
                end
                6: begin
                    line_q.push_back(QUOTE_CH);
                    line_q.push_back(plain_byte());
                    line_q.push_back(QUOTE_CH);
                    line_q.push_back(plain_byte());
                end
                default: repeat ($urandom_range(1, 5)) line_q.push_back(plain_byte());
            endcase
        end
        case ($urandom_range(4))
            1: line_q.push_back(LF_CH);
            2: begin
                line_q.push_back(CR_CH);
                line_q.push_back(LF_CH);
            end
            3: line_q.push_back(CR_CH);
            4: line_q.push_back(COMMA_CH);
            default: ;
        endcase
        if (line_q.size() == 0)
            line_q.push_back(LF_CH);
    endtask

    task automatic run_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            gen_line();
            sent += line_q.size();
            send_line();
        end
    endtask

    initial begin : main
        int lims[9];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        pin_on    = 1'b0;
        pin_desc  = '0;
        errors    = 0;
        src_idle  = 12;
        dst_idle  = 85;
        hold_req  = 0;
        lims      = '{1, 0, 127, 64, 2, 0, 50, 0, 0};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // quoted fields, empty fields, CR LF trim, quoted comma
        add_row(8'h61,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(COMMA_CH, 1'b0, 1'b1, 0, 0, 1, 1'b0);
        add_row(QUOTE_CH, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(8'h62,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(QUOTE_CH, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(COMMA_CH, 1'b0, 1'b1, 1, 3, 1, 1'b0);
        add_row(COMMA_CH, 1'b0, 1'b1, 2, 6, 0, 1'b0);
        add_row(QUOTE_CH, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(COMMA_CH, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(QUOTE_CH, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(CR_CH,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(LF_CH,    1'b1, 1'b1, 3, 8, 1, 1'b1);
        // trailing comma closes the line
        add_row(8'h78,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(COMMA_CH, 1'b1, 1'b1, 0, 0, 1, 1'b1);
        // zero byte, all-ones byte, lone CR trim
        add_row(8'h00,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(8'hFF,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(CR_CH,    1'b1, 1'b1, 0, 0, 2, 1'b1);
        // lone quote, lone LF, quoted empty field
        add_row(QUOTE_CH, 1'b1, 1'b1, 0, 0, 1, 1'b1);
        add_row(LF_CH,    1'b1, 1'b1, 0, 0, 0, 1'b1);
        add_row(QUOTE_CH, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(QUOTE_CH, 1'b1, 1'b1, 0, 1, 0, 1'b1);
        // leading comma, then LF trim
        add_row(COMMA_CH, 1'b0, 1'b1, 0, 0, 0, 1'b0);
        add_row(8'h61,    1'b0, 1'b0, 0, 0, 0, 1'b0);
        add_row(LF_CH,    1'b1, 1'b1, 1, 1, 1, 1'b1);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].c, dir_rows[i].eol, dir_rows[i].pinned, dir_rows[i].d);
        pin_on = 1'b0;

        // over-long lines: comma at the last kept offset, quoted field across
        // the edge, plain field past the edge
        set_limit(LimitW'(64));
        line_q.delete();
        repeat (2047) line_q.push_back(plain_byte());
        line_q.push_back(COMMA_CH);
        line_q.push_back(8'h78);
        line_q.push_back(8'h79);
        line_q.push_back(LF_CH);
        send_line();
        line_q.delete();
        line_q.push_back(QUOTE_CH);
        repeat (2046) line_q.push_back(plain_byte());
        line_q.push_back(QUOTE_CH);
        line_q.push_back(8'h71);
        line_q.push_back(COMMA_CH);
        line_q.push_back(CR_CH);
        send_line();
        line_q.delete();
        repeat (2050) line_q.push_back(plain_byte());
        send_line();

        for (int p = 0; p < 9; p++) begin
            if (p == 5 || p >= 7)
                lims[p] = $urandom_range(3, 64);
            set_limit(LimitW'(lims[p]));
            if (p < 2) begin
                src_idle = 12;
                dst_idle = 85;
            end else if (p < 6) begin
                src_idle = 85;
                dst_idle = 12;
            end else begin
                src_idle = 0;
                dst_idle = 0;
            end
            if (p == 6 || p == 8)
                hold_req = 120;
            run_random((lims[p] == 0) ? 30 : 160);
        end

        s_tvalid <= 1'b0;
        wait (desc_q.size() == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0 && desc_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
